>>> rtl/rgb_to_yuv420_converter_macros.svh
// ---------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_YUV420_CONVERTER_MACROS_SVH
`define RGB_TO_YUV420_CONVERTER_MACROS_SVH

// same-cycle implication
`define RYUV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ryuv assertion failed");

// next-cycle implication
`define RYUV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ryuv assertion failed");

`endif

>>> rtl/ryuv_pkg.sv
// ---------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter package
// Payload types, register indexes and size defaults.
// ---------------------------------------------------------------------------
package ryuv_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 2048;
    localparam int unsigned MAX_HEIGHT_DEF = 2048;

    localparam int unsigned DIM_W     = 12;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CPOS_W    = 10;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0]        luma;
        logic              chroma_valid;
        logic [7:0]        cb;
        logic [7:0]        cr;
        logic [CPOS_W-1:0] chroma_col;
        logic [CPOS_W-1:0] chroma_row;
        logic              frame_end;
    } t_result;

    // horizontal pair sum, 9 bits per channel
    typedef struct packed {
        logic [8:0] r;
        logic [8:0] g;
        logic [8:0] b;
    } t_pair;

    // what the front end hands the color stage
    typedef struct packed {
        t_pixel            pixel;
        t_pair             pair;
        logic              chroma_valid;
        logic              use_above;
        logic [CPOS_W-1:0] chroma_col;
        logic [CPOS_W-1:0] chroma_row;
        logic              frame_end;
    } t_stage1;

endpackage

>>> rtl/ryuv_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module ryuv_ram #(
    parameter int unsigned WIDTH = 27,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/ryuv_front.sv
// ---------------------------------------------------------------------------
// Converter front end
// Raster position, horizontal pair sums, line store and the input register.
// ---------------------------------------------------------------------------
module ryuv_front #(
    parameter int unsigned MAX_WIDTH  = ryuv_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = ryuv_pkg::MAX_HEIGHT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  ryuv_pkg::t_pixel           i_pixel,
    input  logic [ryuv_pkg::DIM_W-1:0] i_frame_width,
    input  logic [ryuv_pkg::DIM_W-1:0] i_frame_height,
    output ryuv_pkg::t_stage1          o_s1,
    output ryuv_pkg::t_pair            o_above
);

    localparam int unsigned CW    = $clog2(MAX_WIDTH);
    localparam int unsigned RW    = $clog2(MAX_HEIGHT);
    localparam int unsigned DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    ryuv_pkg::t_pixel  r_pending;
    ryuv_pkg::t_stage1 r_s1;

    logic [CW-1:0]        w_last;
    logic [RW-1:0]        h_last;
    logic                 last_col, last_row, even_row, pair_done;
    ryuv_pkg::t_pair      pair;
    logic [AW-1:0]        addr;
    logic                 wr_en, rd_en;
    logic [$bits(ryuv_pkg::t_pair)-1:0] rd_data;

    // zero acts as one, oversize saturates
    always_comb begin
        if (i_frame_width == '0) begin
            w_last = '0;
        end else if (32'(i_frame_width) > MAX_WIDTH) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(i_frame_width - 1'b1);
        end
        if (i_frame_height == '0) begin
            h_last = '0;
        end else if (32'(i_frame_height) > MAX_HEIGHT) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(i_frame_height - 1'b1);
        end
    end

    assign last_col  = (r_col >= w_last);
    assign last_row  = (r_row >= h_last);
    assign even_row  = ~r_row[0];
    assign pair_done = r_col[0] | last_col;

    // odd last column doubles the edge pixel
    always_comb begin
        if (r_col[0]) begin
            pair.r = {1'b0, r_pending.red}   + {1'b0, i_pixel.red};
            pair.g = {1'b0, r_pending.green} + {1'b0, i_pixel.green};
            pair.b = {1'b0, r_pending.blue}  + {1'b0, i_pixel.blue};
        end else begin
            pair.r = {i_pixel.red,   1'b0};
            pair.g = {i_pixel.green, 1'b0};
            pair.b = {i_pixel.blue,  1'b0};
        end
    end

    assign addr  = AW'(r_col >> 1);
    assign wr_en = i_accept & pair_done & even_row & ~last_row;
    assign rd_en = i_accept & pair_done & ~even_row;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_pending <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!r_col[0]) begin
                r_pending <= i_pixel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1.pixel        <= i_pixel;
            r_s1.pair         <= pair;
            r_s1.chroma_valid <= pair_done & (~even_row | last_row);
            r_s1.use_above    <= ~even_row;
            r_s1.chroma_col   <= ryuv_pkg::CPOS_W'(r_col >> 1);
            r_s1.chroma_row   <= ryuv_pkg::CPOS_W'(r_row >> 1);
            r_s1.frame_end    <= last_col & last_row;
        end
    end

    ryuv_ram #(
        .WIDTH ($bits(ryuv_pkg::t_pair)),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (addr),
        .i_wr_data (pair),
        .i_rd_en   (rd_en),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    assign o_s1    = r_s1;
    assign o_above = ryuv_pkg::t_pair'(rd_data);

endmodule

>>> rtl/ryuv_color.sv
// ---------------------------------------------------------------------------
// Converter color stage
// Luma, 2x2 chroma average and Cb/Cr, into the result register.
// ---------------------------------------------------------------------------
module ryuv_color (
    input  logic              i_clk,
    input  logic              i_load,
    input  ryuv_pkg::t_stage1 i_s1,
    input  ryuv_pkg::t_pair   i_above,
    output ryuv_pkg::t_result o_result
);

    localparam logic [16:0] OFFSET = 17'd32768;

    ryuv_pkg::t_result r_result;

    logic [15:0] y_sum;
    logic [9:0]  sum_r, sum_g, sum_b;
    logic [7:0]  ar, ag, ab;
    logic [16:0] cb_sum, cr_sum;

    assign y_sum = 16'd77  * 16'(i_s1.pixel.red)
                 + 16'd150 * 16'(i_s1.pixel.green)
                 + 16'd29  * 16'(i_s1.pixel.blue);

    // odd last row doubles the even row's pair
    always_comb begin
        if (i_s1.use_above) begin
            sum_r = 10'(i_above.r) + 10'(i_s1.pair.r);
            sum_g = 10'(i_above.g) + 10'(i_s1.pair.g);
            sum_b = 10'(i_above.b) + 10'(i_s1.pair.b);
        end else begin
            sum_r = {i_s1.pair.r, 1'b0};
            sum_g = {i_s1.pair.g, 1'b0};
            sum_b = {i_s1.pair.b, 1'b0};
        end
    end

    assign ar = sum_r[9:2];
    assign ag = sum_g[9:2];
    assign ab = sum_b[9:2];

    // offset sum stays within 128..65408, so the shifted value never needs clamping
    assign cb_sum = OFFSET + 17'd128 * 17'(ab) - 17'd43 * 17'(ar) - 17'd85 * 17'(ag);
    assign cr_sum = OFFSET + 17'd128 * 17'(ar) - 17'd107 * 17'(ag) - 17'd21 * 17'(ab);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result.luma         <= y_sum[15:8];
            r_result.chroma_valid <= i_s1.chroma_valid;
            r_result.frame_end    <= i_s1.frame_end;
            if (i_s1.chroma_valid) begin
                r_result.cb         <= cb_sum[15:8];
                r_result.cr         <= cr_sum[15:8];
                r_result.chroma_col <= i_s1.chroma_col;
                r_result.chroma_row <= i_s1.chroma_row;
            end else begin
                r_result.cb         <= '0;
                r_result.cr         <= '0;
                r_result.chroma_col <= '0;
                r_result.chroma_row <= '0;
            end
        end
    end

    assign o_result = r_result;

endmodule

>>> rtl/rgb_to_yuv420_converter.sv
// ---------------------------------------------------------------------------
// RGB888 to YUV 4:2:0 converter (BT.601 full range)
// One luma per pixel, one Cb/Cr pair per 2x2 block, raster-order input.
// ---------------------------------------------------------------------------
//  channel  | signals                        | handshake
//  ---------+--------------------------------+-------------------------
//  pixel in | i_pixel                        | i_valid / o_stall
//  result   | o_result                       | o_valid / i_stall
//  config   | i_cfg_index, i_cfg_data        | i_cfg_valid / o_cfg_ready
//
// One pixel per clock while o_stall is low.
// Input register (with the line store's registered read) and result register
// form the two stages; the line store read sets the depth.
// Reset is synchronous; counters return to the frame origin, no store clear.
// A stalled result holds; a pixel is still taken into an empty input stage.
// ---------------------------------------------------------------------------
`include "rgb_to_yuv420_converter_macros.svh"

module rgb_to_yuv420_converter #(
    parameter int unsigned MAX_WIDTH  = ryuv_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = ryuv_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  ryuv_pkg::t_pixel               i_pixel,
    output logic                           o_stall,
    output logic                           o_valid,
    output ryuv_pkg::t_result              o_result,
    input  logic                           i_stall,
    input  logic                           i_cfg_valid,
    input  logic [ryuv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ryuv_pkg::DIM_W-1:0]     i_cfg_data,
    output logic                           o_cfg_ready
);

    logic r_v1, r_v2;
    logic [ryuv_pkg::DIM_W-1:0] r_frame_width, r_frame_height;

    logic en1, en2, accept;
    ryuv_pkg::t_stage1 s1;
    ryuv_pkg::t_pair   above;

    assign en2    = ~r_v2 | ~i_stall;
    assign en1    = ~r_v1 | en2;
    assign accept = i_valid & en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= ryuv_pkg::FRAME_WIDTH_RST;
            r_frame_height <= ryuv_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ryuv_pkg::CFG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data;
            end else if (i_cfg_index == ryuv_pkg::CFG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_data;
            end
        end
    end

    ryuv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_pixel        (i_pixel),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_s1           (s1),
        .o_above        (above)
    );

    ryuv_color u_color (
        .i_clk    (i_clk),
        .i_load   (en2 & r_v1),
        .i_s1     (s1),
        .i_above  (above),
        .o_result (o_result)
    );

    assign o_stall     = ~en1;
    assign o_valid     = r_v2;
    assign o_cfg_ready = 1'b1;

    `RYUV_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_stall, r_v1 && r_v2 && i_stall)
    `RYUV_ASSERT_NOW(a_end_has_chroma, i_clk, i_rst_n, o_valid && o_result.frame_end, o_result.chroma_valid)
    `RYUV_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, accept, r_v1)

endmodule

>>> verif/rgb_to_yuv420_converter_tb.sv
// ---------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter testbench
// A directed table covers reset sizes, a mid-frame size change, 1x1 frames,
// zero sizes and odd edges. Random frames follow under several idle patterns,
// then a frame under a long result hold-off and a frame with a mid-frame pause.
// Every result is checked field by field against the predictor or a typed value.
// ---------------------------------------------------------------------------
module rgb_to_yuv420_converter_tb;

    localparam int unsigned STORE_DEPTH   = (ryuv_pkg::MAX_WIDTH_DEF + 1) / 2;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RANDOM_ITEMS  = 560;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned MAX_GAP       = 64;
    localparam int unsigned PRINT_CAP     = 50;
    localparam int unsigned LIMIT_TIME    = 4_000_000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum logic {ROW_PIXEL, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind                  kind;
        ryuv_pkg::t_cfg_index       reg_idx;
        logic [ryuv_pkg::DIM_W-1:0] reg_data;
        ryuv_pkg::t_pixel           pix;
        bit                         typed;
        ryuv_pkg::t_result          want;
    } t_dir_row;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_valid     = 1'b0;
    ryuv_pkg::t_pixel               i_pixel     = '0;
    logic                           o_stall;
    logic                           o_valid;
    ryuv_pkg::t_result              o_result;
    logic                           i_stall     = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic [ryuv_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ryuv_pkg::DIM_W-1:0]     i_cfg_data  = '0;
    logic                           o_cfg_ready;

    // predictor state
    logic [ryuv_pkg::DIM_W-1:0] pred_width  = ryuv_pkg::FRAME_WIDTH_RST;
    logic [ryuv_pkg::DIM_W-1:0] pred_height = ryuv_pkg::FRAME_HEIGHT_RST;
    ryuv_pkg::t_pair            line_pairs [STORE_DEPTH];
    ryuv_pkg::t_pair            half_pixel  = '0;
    int unsigned                col_pos     = 0;
    int unsigned                row_pos     = 0;

    ryuv_pkg::t_result          yuv_expected [$];
    int unsigned                errors        = 0;
    t_idle_mode                 idle_mode     = IDLE_NONE;
    int unsigned                hold_requests = 0;
    int unsigned                hold_seen     = 0;
    int unsigned                hold_left     = 0;
    bit                         typed_on      = 1'b0;
    ryuv_pkg::t_result          typed_res     = '0;

    rgb_to_yuv420_converter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_pixel    (i_pixel),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_stall    (i_stall),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg_ready(o_cfg_ready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        foreach (line_pairs[k]) line_pairs[k] = '0;
    end

    function automatic int unsigned eff_dim(input logic [ryuv_pkg::DIM_W-1:0] v,
                                            input int unsigned maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : int'(v);
    endfunction

    function automatic logic [7:0] clamp_byte(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return 8'(v);
    endfunction

    // Advances the predictor by one pixel and returns the result it causes.
    function automatic ryuv_pkg::t_result predict_pixel(input ryuv_pkg::t_pixel p);
        ryuv_pkg::t_result res;
        ryuv_pkg::t_pair   cur;
        ryuv_pkg::t_pair   pair_sum;
        ryuv_pkg::t_pair   above;
        int unsigned       w;
        int unsigned       h;
        int unsigned       idx;
        int                sr, sg, sb;
        int                ar, ag, ab;
        bit                last_col;
        bit                last_row;
        bit                pair_done;
        bit                chroma_on;
        res       = '0;
        pair_sum  = '0;
        pair_done = 1'b0;
        chroma_on = 1'b0;
        sr = 0; sg = 0; sb = 0;
        w = eff_dim(pred_width, ryuv_pkg::MAX_WIDTH_DEF);
        h = eff_dim(pred_height, ryuv_pkg::MAX_HEIGHT_DEF);
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);
        idx = (col_pos >> 1) % STORE_DEPTH;
        cur = '{r: {1'b0, p.red}, g: {1'b0, p.green}, b: {1'b0, p.blue}};
        res.luma = 8'((77 * int'(p.red) + 150 * int'(p.green) + 29 * int'(p.blue)) >> 8);

        if (col_pos % 2 == 0) begin
            half_pixel = cur;
            if (last_col) begin
                // odd last column: edge pixel doubled
                pair_sum  = '{r: cur.r << 1, g: cur.g << 1, b: cur.b << 1};
                pair_done = 1'b1;
            end
        end else begin
            pair_sum  = '{r: half_pixel.r + cur.r, g: half_pixel.g + cur.g,
                          b: half_pixel.b + cur.b};
            pair_done = 1'b1;
        end

        if (pair_done) begin
            if (row_pos % 2 == 0) begin
                if (last_row) begin
                    // odd last row: even-row pair doubled
                    sr = 2 * int'(pair_sum.r);
                    sg = 2 * int'(pair_sum.g);
                    sb = 2 * int'(pair_sum.b);
                    chroma_on = 1'b1;
                end else begin
                    line_pairs[idx] = pair_sum;
                end
            end else begin
                above = line_pairs[idx];
                sr = int'(above.r) + int'(pair_sum.r);
                sg = int'(above.g) + int'(pair_sum.g);
                sb = int'(above.b) + int'(pair_sum.b);
                chroma_on = 1'b1;
            end
        end

        if (chroma_on) begin
            ar = sr / 4;
            ag = sg / 4;
            ab = sb / 4;
            res.chroma_valid = 1'b1;
            res.cb = clamp_byte(((-43 * ar - 85 * ag + 128 * ab) + 32768) >>> 8);
            res.cr = clamp_byte(((128 * ar - 107 * ag - 21 * ab) + 32768) >>> 8);
            res.chroma_col = ryuv_pkg::CPOS_W'(col_pos >> 1);
            res.chroma_row = ryuv_pkg::CPOS_W'(row_pos >> 1);
        end
        res.frame_end = last_col && last_row;

        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (errors < PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic check_result(input ryuv_pkg::t_result got,
                                input ryuv_pkg::t_result want);
        if (got.luma != want.luma) report_mismatch("luma", got.luma, want.luma);
        if (got.chroma_valid != want.chroma_valid)
            report_mismatch("chroma_valid", got.chroma_valid, want.chroma_valid);
        if (got.cb != want.cb) report_mismatch("cb", got.cb, want.cb);
        if (got.cr != want.cr) report_mismatch("cr", got.cr, want.cr);
        if (got.chroma_col != want.chroma_col)
            report_mismatch("chroma_col", got.chroma_col, want.chroma_col);
        if (got.chroma_row != want.chroma_row)
            report_mismatch("chroma_row", got.chroma_row, want.chroma_row);
        if (got.frame_end != want.frame_end)
            report_mismatch("frame_end", got.frame_end, want.frame_end);
    endtask

    // Sampling at the rising edge: register writes, accepted pixels, results.
    always @(posedge i_clk) begin
        ryuv_pkg::t_result predicted;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == ryuv_pkg::CFG_FRAME_WIDTH) pred_width = i_cfg_data;
                else pred_height = i_cfg_data;
            end
            if (i_valid && !o_stall) begin
                predicted = predict_pixel(i_pixel);
                yuv_expected.push_back(typed_on ? typed_res : predicted);
            end
            if (o_valid && !i_stall) begin
                if (yuv_expected.size() == 0)
                    report_mismatch("result with no pixel request pending", 1, 0);
                else
                    check_result(o_result, yuv_expected.pop_front());
            end
        end
    end

    // Result-side stall; long hold-offs are counted here.
    always @(negedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            case (idle_mode)
                IDLE_RECEIVER: i_stall <= ($urandom_range(99) < 77);
                IDLE_BOTH:     i_stall <= ($urandom_range(99) < 10);
                default:       i_stall <= 1'b0;
            endcase
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned pct;
        int unsigned gap;
        pct = (idle_mode == IDLE_SENDER) ? 77 : (idle_mode == IDLE_BOTH) ? 10 : 0;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < pct) gap++;
        return gap;
    endfunction

    function automatic logic [7:0] rand_level();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    function automatic ryuv_pkg::t_pixel random_pixel();
        return '{red: rand_level(), green: rand_level(), blue: rand_level()};
    endfunction

    task automatic push_pixel(input ryuv_pkg::t_pixel p, input int unsigned gap,
                              input bit typed, input ryuv_pkg::t_result want);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        typed_on  = typed;
        typed_res = want;
        i_valid  <= 1'b1;
        i_pixel  <= p;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (yuv_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input ryuv_pkg::t_cfg_index idx,
                             input logic [ryuv_pkg::DIM_W-1:0] data);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Whole frames only, so the line store is always written before it is read.
    task automatic run_phase(input logic [ryuv_pkg::DIM_W-1:0] w,
                             input logic [ryuv_pkg::DIM_W-1:0] h,
                             input int unsigned frames, input t_idle_mode mode,
                             input bit long_hold, input bit mid_pause,
                             output int unsigned sent);
        int unsigned k;
        cfg_write(ryuv_pkg::CFG_FRAME_WIDTH, w);
        cfg_write(ryuv_pkg::CFG_FRAME_HEIGHT, h);
        idle_mode = mode;
        sent = eff_dim(w, ryuv_pkg::MAX_WIDTH_DEF) * eff_dim(h, ryuv_pkg::MAX_HEIGHT_DEF)
             * frames;
        if (long_hold) hold_requests++;
        for (k = 0; k < sent; k++) begin
            if (mid_pause && k == sent / 2) drain_results();
            push_pixel(random_pixel(), pick_gap(), 1'b0, '0);
        end
    endtask

    function automatic t_dir_row px(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
        t_dir_row row;
        row = '{kind: ROW_PIXEL, reg_idx: ryuv_pkg::CFG_FRAME_WIDTH, reg_data: '0,
                pix: '{red: r, green: g, blue: b}, typed: 1'b0, want: '0};
        return row;
    endfunction

    // pixel with a result that can be written down directly (block origin)
    function automatic t_dir_row px_known(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [7:0] y,
                                          input logic cv, input logic [7:0] u,
                                          input logic [7:0] v, input logic fe);
        t_dir_row row;
        row = px(r, g, b);
        row.typed = 1'b1;
        row.want  = '{luma: y, chroma_valid: cv, cb: u, cr: v, chroma_col: '0,
                      chroma_row: '0, frame_end: fe};
        return row;
    endfunction

    function automatic t_dir_row cfg_row(input ryuv_pkg::t_cfg_index idx,
                                         input logic [ryuv_pkg::DIM_W-1:0] d);
        t_dir_row row;
        row = px(8'd0, 8'd0, 8'd0);
        row.kind     = ROW_CONFIG;
        row.reg_idx  = idx;
        row.reg_data = d;
        return row;
    endfunction

    initial begin
        #(LIMIT_TIME);
        $display("rgb_to_yuv420_converter regression: fail");
        $finish;
    end

    initial begin
        t_dir_row                   dir_rows [$];
        int unsigned                random_count;
        int unsigned                phase;
        int unsigned                sent;
        logic [ryuv_pkg::DIM_W-1:0] w;
        logic [ryuv_pkg::DIM_W-1:0] h;

        // reset sizes 640x480, first row
        dir_rows.push_back(px_known(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0));
        dir_rows.push_back(px_known(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 1'b0));
        dir_rows.push_back(px_known(8'd255, 8'd0, 8'd0, 8'd76, 1'b0, 8'd0, 8'd0, 1'b0));
        dir_rows.push_back(px_known(8'd0, 8'd255, 8'd0, 8'd149, 1'b0, 8'd0, 8'd0, 1'b0));
        dir_rows.push_back(px_known(8'd0, 8'd0, 8'd255, 8'd28, 1'b0, 8'd0, 8'd0, 1'b0));
        // shrink mid-frame: column 5 is now past the last column
        dir_rows.push_back(cfg_row(ryuv_pkg::CFG_FRAME_WIDTH, 12'd2));
        dir_rows.push_back(px(8'd10, 8'd20, 8'd30));
        dir_rows.push_back(cfg_row(ryuv_pkg::CFG_FRAME_HEIGHT, 12'd2));
        dir_rows.push_back(px_known(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 1'b0));
        dir_rows.push_back(px_known(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd128, 8'd128,
                                    1'b1));
        // 1x1 frames: every pixel is a whole block and a whole frame
        dir_rows.push_back(cfg_row(ryuv_pkg::CFG_FRAME_WIDTH, 12'd1));
        dir_rows.push_back(cfg_row(ryuv_pkg::CFG_FRAME_HEIGHT, 12'd1));
        dir_rows.push_back(px_known(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd128, 8'd128, 1'b1));
        dir_rows.push_back(px_known(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd128, 8'd128,
                                    1'b1));
        dir_rows.push_back(px(8'd0, 8'd0, 8'd255));
        dir_rows.push_back(px(8'd255, 8'd0, 8'd0));
        dir_rows.push_back(px(8'd255, 8'd255, 8'd0));
        // zero sizes act as one
        dir_rows.push_back(cfg_row(ryuv_pkg::CFG_FRAME_WIDTH, 12'd0));
        dir_rows.push_back(cfg_row(ryuv_pkg::CFG_FRAME_HEIGHT, 12'd0));
        dir_rows.push_back(px(8'd0, 8'd255, 8'd255));
        dir_rows.push_back(px_known(8'd128, 8'd128, 8'd128, 8'd128, 1'b1, 8'd128, 8'd128,
                                    1'b1));
        // 3x3: odd last column and odd last row
        dir_rows.push_back(cfg_row(ryuv_pkg::CFG_FRAME_WIDTH, 12'd3));
        dir_rows.push_back(cfg_row(ryuv_pkg::CFG_FRAME_HEIGHT, 12'd3));
        dir_rows.push_back(px(8'd12, 8'd200, 8'd7));
        dir_rows.push_back(px(8'd250, 8'd3, 8'd90));
        dir_rows.push_back(px(8'd0, 8'd0, 8'd255));
        dir_rows.push_back(px(8'd64, 8'd32, 8'd16));
        dir_rows.push_back(px(8'd255, 8'd128, 8'd0));
        dir_rows.push_back(px(8'd1, 8'd254, 8'd127));
        dir_rows.push_back(px(8'd255, 8'd0, 8'd255));
        dir_rows.push_back(px(8'd99, 8'd180, 8'd45));
        dir_rows.push_back(px(8'd0, 8'd255, 8'd0));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CONFIG)
                cfg_write(dir_rows[k].reg_idx, dir_rows[k].reg_data);
            else
                push_pixel(dir_rows[k].pix, 0, dir_rows[k].typed, dir_rows[k].want);
        end

        random_count = 0;
        phase = 0;
        while (random_count < RANDOM_ITEMS) begin
            if ($urandom_range(19) == 0) w = '0;
            else if ($urandom_range(3) == 0) w = ryuv_pkg::DIM_W'($urandom_range(13, 48));
            else w = ryuv_pkg::DIM_W'($urandom_range(1, 12));
            h = ($urandom_range(19) == 0) ? '0 : ryuv_pkg::DIM_W'($urandom_range(1, 7));
            run_phase(w, h, $urandom_range(1, 3), t_idle_mode'(phase % 4), 1'b0, 1'b0,
                      sent);
            random_count += sent;
            phase++;
        end

        // long result hold-off while pixels keep coming; then a pause mid-frame
        run_phase(12'd48, 12'd4, 1, IDLE_NONE, 1'b1, 1'b0, sent);
        run_phase(12'd5, 12'd6, 1, IDLE_BOTH, 1'b0, 1'b1, sent);

        drain_results();
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);
        if (errors == 0)
            $display("rgb_to_yuv420_converter regression: pass");
        else
            $display("rgb_to_yuv420_converter regression: fail");
        $finish;
    end

endmodule
